[src/lpfs_pkg.sv]
// shared types and constants for the length prefixed frame splitter
package lpfs_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 32;
  localparam int ACC_W      = LEN_W - BYTE_W;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  typedef enum logic [5:0] {
    PH_LEN0 = 6'b000001,
    PH_LEN1 = 6'b000010,
    PH_LEN2 = 6'b000100,
    PH_LEN3 = 6'b001000,
    PH_CODE = 6'b010000,
    PH_BODY = 6'b100000
  } phase_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
    logic              link_error;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              frame_start;
    logic              header_byte;
    logic              frame_end;
    logic [BYTE_W-1:0] msg_code;
    logic              code_present;
    logic              code_match;
    logic              error_flag;
  } res_t;

endpackage

[src/lpfs_in_reg.sv]
// input register stage of the frame splitter
module lpfs_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lpfs_pkg::IN_DATA_W-1:0] in_tdata,  // rx_byte
  input  logic                          in_tuser,  // link_error
  input  logic                          adv,
  output lpfs_pkg::in_item_t            s0
);
  import lpfs_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              err_r;

  assign in_tready = !valid_r || adv;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata[BYTE_W-1:0];
      err_r  <= in_tuser;
    end
  end

  assign s0.valid      = valid_r;
  assign s0.rx_byte    = byte_r;
  assign s0.link_error = err_r;

endmodule

[src/lpfs_deframe.sv]
// framing state and per item decode of the frame splitter
module lpfs_deframe (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpfs_pkg::in_item_t         s0,
  input  logic                       adv,
  input  logic [lpfs_pkg::BYTE_W-1:0] match_code,
  output lpfs_pkg::res_t             res
);
  import lpfs_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [BYTE_W-1:0] code_r, code_nxt;
  logic [LEN_W-1:0]  rem_dec;
  logic [LEN_W-1:0]  len;
  logic              fire;
  logic [BYTE_W-1:0] b;

  assign fire    = s0.valid && adv;
  assign b       = s0.rx_byte;
  assign rem_dec = rem_r - LEN_W'(1);
  assign len     = {acc_r, b};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    code_nxt  = code_r;
    res       = '0;
    if (s0.link_error) begin
      res.error_flag = 1'b1;
    end else begin
      res.byte_out = b;
      case (phase_r)
        PH_LEN1: begin
          res.header_byte = 1'b1;
          acc_nxt         = {acc_r[ACC_W-BYTE_W-1:0], b};
          phase_nxt       = PH_LEN2;
        end
        PH_LEN2: begin
          res.header_byte = 1'b1;
          acc_nxt         = {acc_r[ACC_W-BYTE_W-1:0], b};
          phase_nxt       = PH_LEN3;
        end
        PH_LEN3: begin
          res.header_byte = 1'b1;
          rem_nxt         = len;
          if (len == '0) begin
            res.frame_end = 1'b1;
            phase_nxt     = PH_LEN0;
          end else begin
            phase_nxt = PH_CODE;
          end
        end
        PH_CODE: begin
          code_nxt = b;
          rem_nxt  = rem_dec;
          if (rem_dec == '0) begin
            res.frame_end    = 1'b1;
            res.code_present = 1'b1;
            res.msg_code     = b;
            res.code_match   = (b == match_code);
            phase_nxt        = PH_LEN0;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            res.frame_end    = 1'b1;
            res.code_present = 1'b1;
            res.msg_code     = code_r;
            res.code_match   = (code_r == match_code);
            phase_nxt        = PH_LEN0;
          end
        end
        default: begin
          res.frame_start = 1'b1;
          res.header_byte = 1'b1;
          acc_nxt         = ACC_W'(b);
          code_nxt        = '0;
          phase_nxt       = PH_LEN1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN0;
      acc_r   <= '0;
      rem_r   <= '0;
      code_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

[src/lpfs_out_reg.sv]
// result register stage of the frame splitter
module lpfs_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s0_valid,
  input  lpfs_pkg::res_t                  res,
  output logic                            adv,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // byte_out, msg_code, code_present, code_match, zero fill
  output logic [lpfs_pkg::OUT_DATA_W-1:0] out_tdata,
  // frame_start, header_byte, error_flag
  output logic [lpfs_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast
);
  import lpfs_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign adv = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {6'b0, res_r.code_match, res_r.code_present,
                       res_r.msg_code, res_r.byte_out};
  assign out_tuser  = {res_r.error_flag, res_r.header_byte, res_r.frame_start};
  assign out_tlast  = res_r.frame_end;

endmodule

[src/length_prefixed_frame_splitter_core.sv]
// top level of the length prefixed frame splitter
// an accepted item goes through the input register and then the result register to the output
// throughput: one item per cycle if out_tready is high (one decode step between registers)
// ready toward the input follows out_tready combinationally through both stages
// reset (rst_n low, synchronous): both stages empty, framing waits for a first length byte,
// match code cleared to zero
module length_prefixed_frame_splitter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpfs_pkg::BYTE_W-1:0]     cfg_wdata,   // match code
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lpfs_pkg::IN_DATA_W-1:0]  in_tdata,    // rx_byte
  input  logic                            in_tuser,    // link_error
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // byte_out, msg_code, code_present, code_match, zero fill
  output logic [lpfs_pkg::OUT_DATA_W-1:0] out_tdata,
  // frame_start, header_byte, error_flag
  output logic [lpfs_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                            out_tlast    // frame_end
);
  import lpfs_pkg::*;

  logic [BYTE_W-1:0] exp_code_r;
  in_item_t          s0;
  res_t              res;
  logic              adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_code_r <= '0;
    end else if (cfg_we) begin
      exp_code_r <= cfg_wdata;
    end
  end

  lpfs_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .adv       (adv),
    .s0        (s0)
  );

  lpfs_deframe u_deframe (
    .clk        (clk),
    .rst_n      (rst_n),
    .s0         (s0),
    .adv        (adv),
    .match_code (exp_code_r),
    .res        (res)
  );

  lpfs_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .s0_valid   (s0.valid),
    .res        (res),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s0.valid)
    else $error("accepted item did not reach the input stage");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == '0 && !out_tlast && out_tuser[1:0] == 2'b00)
    else $error("error item carries data or marks");

  a_match_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> out_tdata[16] && out_tlast)
    else $error("code match without present code at frame end");

  a_header_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tdata[16] && out_tdata[15:8] == '0)
    else $error("length byte reports a message code");
`endif

endmodule

[tb/tb_top.sv]
// self-checking testbench for the length prefixed frame splitter core
module tb_top;
  import lpfs_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              link_error;
  } rx_item_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [BYTE_W-1:0]     cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  rx_item_t rx_pending[$];
  res_t     expected_marks[$];
  rx_item_t cur_item;

  // deframing state of the predictor
  phase_t            fr_phase   = PH_LEN0;
  logic [LEN_W-1:0]  len_acc    = '0;
  logic [LEN_W-1:0]  bytes_left = '0;
  logic [BYTE_W-1:0] code_seen  = '0;
  logic [BYTE_W-1:0] want_code  = '0;

  int mismatches   = 0;
  int stim_bytes   = 0;
  int results_seen = 0;
  int link_errs    = 0;
  int frames_done  = 0;
  int code_hits    = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  int stall_mode   = 0;
  int stall_timer  = 0;

  always #6 clk = ~clk;

  length_prefixed_frame_splitter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
    end
  endtask

  // advance the deframing state by one accepted item and queue its expected marks
  task automatic deframe_byte(input rx_item_t it);
    res_t r;
    r = '0;
    if (it.link_error) begin
      r.error_flag = 1'b1;
    end else begin
      r.byte_out = it.rx_byte;
      case (fr_phase)
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
          r.header_byte = 1'b1;
          if (fr_phase == PH_LEN0) begin
            r.frame_start = 1'b1;
            code_seen = '0;
            len_acc = '0;
          end
          len_acc = {len_acc[ACC_W-1:0], it.rx_byte};
          if (fr_phase == PH_LEN3) begin
            bytes_left = len_acc;
            if (len_acc == '0) begin
              r.frame_end = 1'b1;
              fr_phase = PH_LEN0;
            end else begin
              fr_phase = PH_CODE;
            end
          end else begin
            fr_phase = phase_t'(fr_phase << 1);
          end
        end
        default: begin
          if (fr_phase == PH_CODE) begin
            code_seen = it.rx_byte;
            fr_phase = PH_BODY;
          end
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            r.frame_end = 1'b1;
            r.code_present = 1'b1;
            r.msg_code = code_seen;
            r.code_match = (code_seen == want_code);
            fr_phase = PH_LEN0;
          end
        end
      endcase
    end
    expected_marks.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic err);
    rx_item_t it;
    it.rx_byte = b;
    it.link_error = err;
    rx_pending.push_back(it);
    if (!err) stim_bytes++;
  endtask

  task automatic maybe_link_error(input int pct);
    if ($urandom_range(0, 99) < pct) push_byte(8'($urandom), 1'b1);
  endtask

  task automatic queue_frame(input int len, input logic [7:0] code, input int noise_pct);
    logic [LEN_W-1:0] lv;
    lv = LEN_W'(len);
    for (int i = 3; i >= 0; i--) begin
      maybe_link_error(noise_pct);
      push_byte(lv[8*i +: 8], 1'b0);
    end
    for (int n = 0; n < len; n++) begin
      maybe_link_error(noise_pct);
      push_byte((n == 0) ? code : 8'($urandom), 1'b0);
    end
  endtask

  task automatic random_frames(input int target);
    int goal;
    int pick;
    int len;
    logic [7:0] code;
    goal = stim_bytes + target;
    while (stim_bytes < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) len = 0;
      else if (pick < 22) len = 1;
      else if (pick < 90) len = $urandom_range(2, 24);
      else if (pick < 97) len = $urandom_range(40, 70);
      else len = $urandom_range(250, 270);
      code = ($urandom_range(0, 1) == 1) ? want_code : 8'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b1);
      end
      queue_frame(len, code, ($urandom_range(0, 3) == 0) ? 10 : 0);
    end
  endtask

  task automatic write_code(input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    want_code = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (rx_pending.size() != 0 || in_tvalid || expected_marks.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      fr_phase = PH_LEN0;
      len_acc = '0;
      bytes_left = '0;
      code_seen = '0;
      want_code = '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) deframe_byte(cur_item);
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          cur_item = rx_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= cur_item.rx_byte;
          in_tuser <= cur_item.link_error;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(0, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each item, stalls in modes that change now and then
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_marks.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_marks.pop_front();
          check_field("byte_out", out_tdata[7:0], want.byte_out);
          check_field("msg_code", out_tdata[15:8], want.msg_code);
          check_field("code_present", 8'(out_tdata[16]), 8'(want.code_present));
          check_field("code_match", 8'(out_tdata[17]), 8'(want.code_match));
          check_field("zero fill", 8'(out_tdata[23:18]), 8'h00);
          check_field("frame_start", 8'(out_tuser[0]), 8'(want.frame_start));
          check_field("header_byte", 8'(out_tuser[1]), 8'(want.header_byte));
          check_field("error_flag", 8'(out_tuser[2]), 8'(want.error_flag));
          check_field("frame_end", 8'(out_tlast), 8'(want.frame_end));
          link_errs += want.error_flag;
          frames_done += want.frame_end;
          code_hits += want.code_match;
        end
      end
      if (stall_timer == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_timer = $urandom_range(50, 300);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    logic [7:0] codes[5];
    codes = '{8'h00, 8'hFF, 8'($urandom), 8'h80, 8'($urandom)};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_code(8'h5A);

    // zero length, one byte matching code, errors inside header and body, mismatch
    queue_frame(0, 8'h00, 0);
    queue_frame(1, 8'h5A, 0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    queue_frame(2, 8'hA5, 0);
    drain();

    foreach (codes[i]) begin
      write_code(codes[i]);
      random_frames(230);
      drain();
    end

    // last frame never completes: all-ones length
    write_code(8'h01);
    queue_frame(3, 8'h01, 0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    repeat (16) begin
      maybe_link_error(15);
      push_byte(8'($urandom), 1'b0);
    end
    drain();

    $display("sent %0d bytes and %0d link errors, %0d results checked",
             stim_bytes, link_errs, results_seen);
    $display("%0d frames completed, %0d with a matching code", frames_done, code_hits);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(12 * 300000);
    $display("tb_top failed");
    $finish;
  end

endmodule
